// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int TAG_W   = 16;
  localparam int SEV_W   = 10;
  localparam int STAMP_W = 32;
  localparam int DATA_W  = 32;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [SEV_W-1:0]   sev;
    logic [TAG_W-1:0]   tag;
  } cell_t;

endpackage

// ===== hdl/stable_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded stable max-priority queue with a single-port scan sequencer.
// ----------------------------------------------------------------------------
// Entries live in arrival order in a one-read one-write memory. Insert, a
// full insert and an extract on an empty queue hold the input through the
// accept state and the state that loads the result. An extract spends the
// accept state, a scan of all live entries through the one read port and
// one severity comparator, a read and a write for each later entry moved
// down one place, a last read step to finish the gap, and the result load.
// The input is not ready while an item is in progress; one finished result
// may wait in the output register while the next item is accepted, and a
// second result waits until that beat leaves.
module stable_priority_queue_top #(
  parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // entry_tag[15:0], severity[25:16]
  input  logic        s_axis_tuser,   // opcode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_tag[15:0], out_severity[25:16]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHRD, S_SHWR, S_RESP} state_t;

  state_t             state;
  logic [CNT_W-1:0]   occupancy;
  logic [STAMP_W-1:0] arrival_counter;
  logic [CNT_W-1:0]   issue_idx;
  logic               cmp_valid;
  logic [IDX_W-1:0]   cmp_idx;
  cell_t              best;
  logic [IDX_W-1:0]   best_idx;
  logic [IDX_W-1:0]   sh;
  status_t            res_status;
  logic [TAG_W-1:0]   res_tag;
  logic [SEV_W-1:0]   res_sev;
  status_t            out_status;
  logic [TAG_W-1:0]   out_tag;
  logic [SEV_W-1:0]   out_sev;

  logic               in_beat;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  cell_t              wr_data;
  logic [IDX_W-1:0]   rd_addr;
  cell_t              rd_data;
  logic               take;
  cell_t              best_next;
  logic [IDX_W-1:0]   best_idx_next;
  logic               scan_last;
  logic               issue_ok;

  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign issue_ok  = (issue_idx < occupancy);
  assign take      = (cmp_idx == '0) || (rd_data.sev > best.sev);
  assign scan_last = cmp_valid && ((CNT_W'(cmp_idx) + CNT_W'(1)) == occupancy);

  always_comb begin
    best_next     = best;
    best_idx_next = best_idx;
    if (cmp_valid && take) begin
      best_next     = rd_data;
      best_idx_next = cmp_idx;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sh;
    wr_data = rd_data;
    rd_addr = issue_idx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        wr_en         = in_beat && (s_axis_tuser == OP_INSERT) &&
                        (occupancy != CNT_W'(QUEUE_DEPTH));
        wr_addr       = occupancy[IDX_W-1:0];
        wr_data.tag   = s_axis_tdata[TAG_W-1:0];
        wr_data.sev   = s_axis_tdata[TAG_W+SEV_W-1:TAG_W];
        wr_data.stamp = arrival_counter;
      end
      S_SHRD:  rd_addr = sh + IDX_W'(1);
      S_SHWR:  wr_en   = 1'b1;
      default: ;
    endcase
  end

  spq_mem #(.DEPTH(QUEUE_DEPTH), .IDX_W(IDX_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      occupancy       <= '0;
      arrival_counter <= '0;
      cmp_valid       <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_RESP)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          res_tag <= '0;
          res_sev <= '0;
          if (in_beat) begin
            if (s_axis_tuser == OP_INSERT) begin
              state <= S_RESP;
              if (occupancy == CNT_W'(QUEUE_DEPTH)) begin
                res_status <= ST_FULL;
              end else begin
                res_status      <= ST_INSERTED;
                occupancy       <= occupancy + CNT_W'(1);
                arrival_counter <= arrival_counter + STAMP_W'(1);
              end
            end else if (occupancy == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_RESP;
            end else begin
              issue_idx <= '0;
              cmp_valid <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // all reads are issued by the time the last compare lands
          cmp_valid <= issue_ok;
          cmp_idx   <= issue_idx[IDX_W-1:0];
          if (issue_ok) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          best     <= best_next;
          best_idx <= best_idx_next;
          if (scan_last) begin
            res_status <= ST_REMOVED;
            res_tag    <= best_next.tag;
            res_sev    <= best_next.sev;
            sh         <= best_idx_next;
            state      <= S_SHRD;
          end
        end
        S_SHRD: begin
          if ((CNT_W'(sh) + CNT_W'(1)) == occupancy) begin
            occupancy <= occupancy - CNT_W'(1);
            state     <= S_RESP;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          sh    <= sh + IDX_W'(1);
          state <= S_SHRD;
        end
        S_RESP: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= res_status;
            out_tag       <= res_tag;
            out_sev       <= res_sev;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {{(DATA_W-TAG_W-SEV_W){1'b0}}, out_sev, out_tag};
  assign m_axis_tuser = out_status;

endmodule

// ===== hdl/spq_mem.sv =====
// ----------------------------------------------------------------------------
// spq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  spq_pkg::cell_t    wr_data,
  input  logic [IDX_W-1:0]  rd_addr,
  output spq_pkg::cell_t    rd_data
);
  import spq_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import spq_pkg::*;

  // held output beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // only removals carry a payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_REMOVED) |-> m_axis_tdata == 32'd0)
    else $error("nonzero payload on non-removal result");

  // one item at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

  // upper pad bits of the result are zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:26] == 6'd0)
    else $error("pad bits set on output");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_priority_queue_top. A shadow copy of the
// queue, kept in arrival order, predicts the status, tag and severity of
// every result beat. Inserts and extracts are sent with random gaps while the
// output side stalls at random. A run of inserts past the depth, sent under a
// long output hold-off, overflows the queue, and random phases swing the queue
// between empty and full with heavy severity ties.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int QDEPTH        = DEPTH_DEFAULT;
  localparam int RX_HOLD       = 400;
  localparam int SETTLE_CYCLES = 3 * QDEPTH + 16;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RAND_ITEMS    = 890;

  typedef struct {
    status_t     status;
    logic [15:0] tag;
    logic [9:0]  sev;
  } result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // entry_tag[15:0], severity[25:16]
  logic        s_axis_tuser;   // opcode[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // out_tag[15:0], out_severity[25:16]
  logic [1:0]  m_axis_tuser;   // status[1:0]

  logic [15:0] shadow_tag [QDEPTH];
  logic [9:0]  shadow_sev [QDEPTH];
  logic [31:0] shadow_stamp [QDEPTH];
  int          shadow_count = 0;
  logic [31:0] shadow_seq = '0;

  result_t     pending_results [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          hold_reqs = 0;
  int          holds_done = 0;

  stable_priority_queue_top #(.QUEUE_DEPTH(QDEPTH)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic result_t queue_model_step(logic op, logic [15:0] tag, logic [9:0] sev);
    result_t r;
    int      best;
    r.status = ST_INSERTED;
    r.tag    = '0;
    r.sev    = '0;
    best     = 0;
    if (op == OP_INSERT) begin
      if (shadow_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        shadow_tag[shadow_count]   = tag;
        shadow_sev[shadow_count]   = sev;
        shadow_stamp[shadow_count] = shadow_seq;
        shadow_count++;
        shadow_seq++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // strict compare keeps the earliest arrival on a tie
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_sev[i] > shadow_sev[best]) best = i;
      end
      r.status = ST_REMOVED;
      r.tag    = shadow_tag[best];
      r.sev    = shadow_sev[best];
      for (int i = best; i < shadow_count - 1; i++) begin
        shadow_tag[i]   = shadow_tag[i+1];
        shadow_sev[i]   = shadow_sev[i+1];
        shadow_stamp[i] = shadow_stamp[i+1];
      end
      shadow_count--;
    end
    return r;
  endfunction

  function automatic int tx_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!tx_idle_on || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [9:0] pick_severity();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return 10'($urandom_range(0, 3));
    if (roll == 3) return 10'd0;
    if (roll == 4) return 10'h3FF;
    if (roll == 5) return 10'($urandom_range(1020, 1023));
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic send_item(logic op, logic [15:0] tag, logic [9:0] sev, int gap);
    result_t r;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      s_axis_tuser  <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, sev, tag};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    r = queue_model_step(op, tag, sev);
    pending_results.push_back(r);
  endtask

  task automatic quiet_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // output side: random stalls, plus long hold-offs on request
  initial begin
    int stall_left;
    int roll;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD - 1) @(negedge clk);
        holds_done++;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!rx_idle_on) begin
        m_axis_tready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          if (roll < 95) stall_left = $urandom_range(0, 3);
          else stall_left = $urandom_range(15, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d tag %h sev %h",
               m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[25:16]);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tuser !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[15:0] !== exp_r.tag) begin
          $error("out_tag: expected %h, actual %h", exp_r.tag, m_axis_tdata[15:0]);
          mismatches++;
        end
        if (m_axis_tdata[25:16] !== exp_r.sev) begin
          $error("out_severity: expected %h, actual %h", exp_r.sev, m_axis_tdata[25:16]);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed();
    send_item(OP_EXTRACT, 16'hFFFF, 10'h3FF, 0);
    send_item(OP_EXTRACT, 16'h0000, 10'h000, 1);
    send_item(OP_INSERT, 16'h0000, 10'h000, 0);
    send_item(OP_INSERT, 16'hFFFF, 10'h3FF, 0);
    send_item(OP_INSERT, 16'h1234, 10'h3FF, 2);
    send_item(OP_INSERT, 16'h00AA, 10'd5, 0);
    send_item(OP_INSERT, 16'h5555, 10'd5, 0);
    send_item(OP_INSERT, 16'hAAAA, 10'h000, 0);
    repeat (6) send_item(OP_EXTRACT, 16'($urandom), 10'($urandom), tx_gap());
    send_item(OP_EXTRACT, 16'hFFFF, 10'h3FF, 0);
    // removal from the middle closes the gap
    send_item(OP_INSERT, 16'h0101, 10'd1, 0);
    send_item(OP_INSERT, 16'h0909, 10'd9, 0);
    send_item(OP_INSERT, 16'h0102, 10'd1, 0);
    send_item(OP_EXTRACT, 16'h0000, 10'h000, 0);
    send_item(OP_INSERT, 16'h0910, 10'd9, 3);
    repeat (4) send_item(OP_EXTRACT, 16'h0000, 10'h000, 0);
  endtask

  task automatic test_overflow_backpressure();
    tx_idle_on = 1'b0;
    hold_reqs++;
    for (int i = 0; i < QDEPTH + 6; i++) begin
      send_item(OP_INSERT, 16'($urandom), 10'($urandom_range(0, 2)), 0);
    end
    for (int i = 0; i < QDEPTH + 2; i++) begin
      send_item(OP_EXTRACT, 16'($urandom), 10'($urandom), 0);
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          insert_pct;
    int          phase;
    logic        op;
    logic [15:0] tag;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      phase = n / 150;
      case (phase % 4)
        0: insert_pct = 80;
        1: insert_pct = 25;
        2: insert_pct = 55;
        default: insert_pct = 35;
      endcase
      tx_idle_on = (phase % 4) != 2;
      rx_idle_on = (phase % 4) != 1 && (phase % 4) != 2;
      op  = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
      tag = ($urandom_range(0, 19) == 0) ? {16{1'($urandom)}} : 16'($urandom);
      send_item(op, tag, pick_severity(), tx_gap());
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INSERT;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_overflow_backpressure();
    test_random_traffic();
    quiet_input();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/spq_pkg.sv
hdl/spq_mem.sv
hdl/stable_priority_queue_top.sv
hdl/spq_checker.sv
dv/tb.sv
